@@ rtl/pixel_recolor_gradient_assert.svh @@
// Assertion macros for the pixel recolor block.
`ifndef PIXEL_RECOLOR_GRADIENT_ASSERT_SVH
`define PIXEL_RECOLOR_GRADIENT_ASSERT_SVH
`ifndef SYNTH
`define RCG_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pixel_recolor_gradient: check failed");
`define RCG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pixel_recolor_gradient: check failed");
`else
`define RCG_ASSERT_IMPLY(label, ante, cons)
`define RCG_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/rcg_pkg.sv @@
// Shared types, constants and helpers for the pixel recolor block.
package rcg_pkg;

   localparam int MAX_DIM = 4096;
   localparam int DIM_W   = 13;
   localparam int CNT_W   = 12;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_COLOR = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_END_COLOR  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_COLOR  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KEEP_COLOR = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT     = 3'd6;

   typedef struct packed {
      logic [31:0] source_pixel;
      logic        first_of_image;
   } req_type;

   typedef struct packed {
      logic [31:0] result_pixel;
      logic        last_of_image;
   } rsp_type;

   // per-channel signed step, index 2 is red, 0 is blue
   typedef logic [2:0][8:0] steps_type;

   // pixel after the position/color stage
   typedef struct packed {
      logic [31:0] pixel;
      logic [23:0] color;
      logic        last;
   } stage_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end
      return r;
   endfunction

endpackage

@@ rtl/rcg_step_div.sv @@
// Gradient step divider: (end - base) / height per channel, one quotient bit a cycle.
module rcg_step_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [23:0]                  base_color,
   input  logic [23:0]                  end_color,
   input  logic [rcg_pkg::DIM_W-1:0]    height,
   output logic                         busy,
   output rcg_pkg::steps_type           steps
);
   import rcg_pkg::*;

   logic [2:0][7:0]       dvd_ff, dvd_in;
   logic [2:0][7:0]       quo_ff, quo_in;
   logic [2:0][DIM_W-1:0] rem_ff, rem_in;
   logic [2:0]            neg_ff, neg_in;
   logic [2:0]            cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;

   logic [2:0][8:0]       diff;
   logic [2:0][8:0]       mag;
   logic [2:0][DIM_W:0]   trial;
   logic [2:0][DIM_W:0]   trial_sub;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         diff[c]      = {1'b0, end_color[8*c +: 8]} - {1'b0, base_color[8*c +: 8]};
         mag[c]       = diff[c][8] ? 9'(-diff[c]) : diff[c];
         trial[c]     = {rem_ff[c], dvd_ff[c][7]};
         trial_sub[c] = trial[c] - {1'b0, height};
      end
   end

   always_comb begin
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         for (int c = 0; c < 3; c++) begin
            dvd_in[c] = mag[c][7:0];
            neg_in[c] = diff[c][8];
            quo_in[c] = '0;
            rem_in[c] = '0;
         end
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int c = 0; c < 3; c++) begin
            dvd_in[c] = {dvd_ff[c][6:0], 1'b0};
            if (trial[c] >= {1'b0, height}) begin
               rem_in[c] = trial_sub[c][DIM_W-1:0];
               quo_in[c] = {quo_ff[c][6:0], 1'b1};
            end else begin
               rem_in[c] = trial[c][DIM_W-1:0];
               quo_in[c] = {quo_ff[c][6:0], 1'b0};
            end
         end
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quo_ff  <= '0;
         neg_ff  <= '0;
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         quo_ff  <= quo_in;
         neg_ff  <= neg_in;
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   // truncation toward zero: divide magnitudes, then restore the sign
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         steps[c] = neg_ff[c] ? 9'(-{1'b0, quo_ff[c]}) : {1'b0, quo_ff[c]};
      end
   end

   assign busy = busy_ff;

endmodule

@@ rtl/rcg_color.sv @@
// Pixel position tracking and current gradient color for each accepted pixel.
module rcg_color (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic                         first,
   input  logic                         mode,
   input  logic [23:0]                  base_color,
   input  logic [rcg_pkg::DIM_W-1:0]    width,
   input  logic [rcg_pkg::DIM_W-1:0]    height,
   input  rcg_pkg::steps_type           new_steps,
   output logic [23:0]                  color,
   output logic                         last
);
   import rcg_pkg::*;

   logic [CNT_W-1:0]  col_ff, col_in;
   logic [CNT_W-1:0]  row_ff, row_in;
   logic [23:0]       cur_ff, cur_in;
   steps_type         steps_ff, steps_in;

   logic [DIM_W-1:0]  col_e, row_e;
   logic [DIM_W-1:0]  col_nx, row_nx;
   logic [23:0]       cur_e, cur_step;
   steps_type         steps_e;
   logic [2:0][9:0]   sum;

   always_comb begin
      if (first) begin
         col_e   = '0;
         row_e   = '0;
         cur_e   = base_color;
         steps_e = new_steps;
      end else begin
         col_e   = ({1'b0, col_ff} >= width)  ? '0 : {1'b0, col_ff};
         row_e   = ({1'b0, row_ff} >= height) ? '0 : {1'b0, row_ff};
         cur_e   = cur_ff;
         steps_e = steps_ff;
      end

      // step each channel with saturation to 0..255
      for (int c = 0; c < 3; c++) begin
         sum[c] = $signed({2'b00, cur_e[8*c +: 8]}) + $signed({steps_e[c][8], steps_e[c]});
         if (sum[c][9]) begin
            cur_step[8*c +: 8] = 8'd0;
         end else if (sum[c][8]) begin
            cur_step[8*c +: 8] = 8'd255;
         end else begin
            cur_step[8*c +: 8] = sum[c][7:0];
         end
      end

      cur_in = (mode && col_e == '0) ? cur_step : cur_e;
      color  = mode ? cur_in : base_color;
      last   = (col_e == width - DIM_W'(1)) && (row_e == height - DIM_W'(1));

      col_nx = col_e + DIM_W'(1);
      row_nx = row_e;
      if (col_nx >= width) begin
         col_nx = '0;
         row_nx = row_e + DIM_W'(1);
         if (row_nx >= height) begin
            row_nx = '0;
         end
      end
      col_in   = col_nx[CNT_W-1:0];
      row_in   = row_nx[CNT_W-1:0];
      steps_in = steps_e;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         cur_ff   <= '0;
         steps_ff <= '0;
      end else if (accept) begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         cur_ff   <= cur_in;
         steps_ff <= steps_in;
      end
   end

endmodule

@@ rtl/rcg_shade.sv @@
// Recolor of one pixel: keep, key replacement or black-value shading.
module rcg_shade (
   input  rcg_pkg::stage_type stage,
   input  logic [23:0]        key_color,
   input  logic [23:0]        keep_color,
   output rcg_pkg::rsp_type   rsp
);
   import rcg_pkg::*;

   logic [23:0] src_rgb;
   logic [7:0]  mx_rg, mx;
   logic [7:0]  black;
   logic [23:0] shaded;

   always_comb begin
      src_rgb = stage.pixel[23:0];
      mx_rg   = (src_rgb[23:16] > src_rgb[15:8]) ? src_rgb[23:16] : src_rgb[15:8];
      mx      = (mx_rg > src_rgb[7:0]) ? mx_rg : src_rgb[7:0];
      black   = 8'd255 - mx;
      for (int c = 0; c < 3; c++) begin
         shaded[8*c +: 8] = (stage.color[8*c +: 8] < black) ? 8'd0
                                                           : stage.color[8*c +: 8] - black;
      end

      priority if (src_rgb == keep_color) begin
         rsp.result_pixel = stage.pixel;
      end else if (src_rgb == key_color) begin
         rsp.result_pixel = {8'hFF, stage.color};
      end else begin
         rsp.result_pixel = {8'hFF, shaded};
      end
      rsp.last_of_image = stage.last;
   end

endmodule

@@ rtl/pixel_recolor_gradient.sv @@
// Pixel recolor with solid or vertical gradient color: one pixel per cycle unless held by rsp_ready or the divider.
// Stage 1 registers the pixel with its current color; stage 2 registers the recolored result.
// A config transfer starts the step divider: req_ready stays low while the start is pending and the divider is busy.
// Reset (synchronous, active high) clears registers to defaults, counters, color and steps.
module pixel_recolor_gradient (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  rcg_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output rcg_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rcg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rcg_pkg::CSR_DAT_W-1:0]   csr_data
);
   import rcg_pkg::*;

   `include "pixel_recolor_gradient_assert.svh"

   logic             mode_ff;
   logic [23:0]      base_ff, end_ff, key_ff, keep_ff;
   logic [DIM_W-1:0] width_ff, height_ff;
   logic             start_ff;

   logic             csr_xfer;
   logic             req_xfer;
   logic             out_adv;
   logic             div_busy;
   steps_type        div_steps;
   logic [DIM_W-1:0] width_c, height_c;
   logic [23:0]      cur_color;
   logic             cur_last;

   logic             s1_valid_ff;
   stage_type        s1_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff, rsp_in;

   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         base_ff   <= '0;
         end_ff    <= '0;
         key_ff    <= 24'hFFFFFF;
         keep_ff   <= '0;
         width_ff  <= DIM_W'(1);
         height_ff <= DIM_W'(1);
         start_ff  <= 1'b0;
      end else begin
         start_ff <= csr_xfer;
         if (csr_xfer) begin
            unique case (csr_index)
               CSR_MODE:       mode_ff   <= csr_data[0];
               CSR_BASE_COLOR: base_ff   <= csr_data[23:0];
               CSR_END_COLOR:  end_ff    <= csr_data[23:0];
               CSR_KEY_COLOR:  key_ff    <= csr_data[23:0];
               CSR_KEEP_COLOR: keep_ff   <= csr_data[23:0];
               CSR_WIDTH:      width_ff  <= csr_data[DIM_W-1:0];
               CSR_HEIGHT:     height_ff <= csr_data[DIM_W-1:0];
               default: ;
            endcase
         end
      end
   end

   assign width_c  = clamp_dim(width_ff);
   assign height_c = clamp_dim(height_ff);

   rcg_step_div u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (start_ff),
      .base_color (base_ff),
      .end_color  (end_ff),
      .height     (height_c),
      .busy       (div_busy),
      .steps      (div_steps)
   );

   assign out_adv   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !div_busy && !start_ff && (!s1_valid_ff || out_adv);
   assign req_xfer  = req_valid && req_ready;

   rcg_color u_color (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_xfer),
      .first      (req_data.first_of_image),
      .mode       (mode_ff),
      .base_color (base_ff),
      .width      (width_c),
      .height     (height_c),
      .new_steps  (div_steps),
      .color      (cur_color),
      .last       (cur_last)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         s1_valid_ff <= 1'b1;
      end else if (out_adv) begin
         s1_valid_ff <= 1'b0;
      end
      if (req_xfer) begin
         s1_ff.pixel <= req_data.source_pixel;
         s1_ff.color <= cur_color;
         s1_ff.last  <= cur_last;
      end
   end

   rcg_shade u_shade (
      .stage      (s1_ff),
      .key_color  (key_ff),
      .keep_color (keep_ff),
      .rsp        (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (out_adv && s1_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a config transfer holds off pixels until the step divider has run
   `RCG_ASSERT_NEXT(a_csr_blocks_req, csr_xfer, !req_ready)
   `RCG_ASSERT_IMPLY(a_no_req_while_div, div_busy, !req_xfer)
   `RCG_ASSERT_NEXT(a_req_enters_stage, req_xfer, s1_valid_ff)
   `RCG_ASSERT_NEXT(a_stage_holds_on_stall, s1_valid_ff && !out_adv, s1_valid_ff)

endmodule

@@ sim/pixel_recolor_gradient_test.sv @@
// Self-checking testbench for the pixel recolor block with solid and gradient color.
`timescale 1ns / 1ps

module pixel_recolor_gradient_test;
   import rcg_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int RANDOM_ITEMS = 2000;
   localparam int DRAIN_CYCLES = 10;

   // Predicts the recolored stream and holds the pixels still owed by the block.
   class recolor_scoreboard;
      logic        grad_mode;
      logic [23:0] base_rgb;
      logic [23:0] end_rgb;
      logic [23:0] key_rgb;
      logic [23:0] keep_rgb;
      logic [12:0] row_len;
      logic [12:0] row_total;
      logic [23:0] tint;
      int          step [3];
      int          col_pos;
      int          row_pos;
      rsp_type     owed_pixels [$];
      int          failures;

      function new();
         grad_mode = 1'b0;
         base_rgb  = '0;
         end_rgb   = '0;
         key_rgb   = 24'hFFFFFF;
         keep_rgb  = '0;
         row_len   = 13'd1;
         row_total = 13'd1;
         tint      = '0;
         step      = '{0, 0, 0};
         col_pos   = 0;
         row_pos   = 0;
         failures  = 0;
      endfunction

      function int fold_dim(logic [12:0] v);
         if (v == '0) return 1;
         if (v > 13'(MAX_DIM)) return MAX_DIM;
         return int'(v);
      endfunction

      // c = 0 is red, 2 is blue
      function int channel(logic [23:0] rgb, int c);
         return int'((rgb >> (16 - 8 * c)) & 24'hFF);
      endfunction

      function int pending();
         return owed_pixels.size();
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DAT_W-1:0] data);
         case (index)
            CSR_MODE:       grad_mode = data[0];
            CSR_BASE_COLOR: base_rgb  = data;
            CSR_END_COLOR:  end_rgb   = data;
            CSR_KEY_COLOR:  key_rgb   = data;
            CSR_KEEP_COLOR: keep_rgb  = data;
            CSR_WIDTH:      row_len   = data[12:0];
            CSR_HEIGHT:     row_total = data[12:0];
            default: ;
         endcase
      endfunction

      function void note_pixel(req_type px);
         int          w;
         int          h;
         int          c;
         int          v;
         int          hi;
         int          blk;
         logic [23:0] color;
         logic [23:0] next;
         logic [23:0] src_rgb;
         rsp_type     exp;
         w = fold_dim(row_len);
         h = fold_dim(row_total);
         if (px.first_of_image) begin
            col_pos = 0;
            row_pos = 0;
            tint = base_rgb;
            for (c = 0; c < 3; c++)
               step[c] = (channel(end_rgb, c) - channel(base_rgb, c)) / h;
         end
         // dimensions may have shrunk since the last image
         if (col_pos >= w) col_pos = 0;
         if (row_pos >= h) row_pos = 0;
         if (grad_mode && col_pos == 0) begin
            next = '0;
            for (c = 0; c < 3; c++) begin
               v = channel(tint, c) + step[c];
               if (v < 0) v = 0;
               if (v > 255) v = 255;
               next = next | (24'(v) << (16 - 8 * c));
            end
            tint = next;
         end
         color = grad_mode ? tint : base_rgb;
         src_rgb = px.source_pixel[23:0];
         if (src_rgb == keep_rgb) begin
            exp.result_pixel = px.source_pixel;
         end else if (src_rgb == key_rgb) begin
            exp.result_pixel = {8'hFF, color};
         end else begin
            hi = 0;
            for (c = 0; c < 3; c++)
               if (channel(src_rgb, c) > hi) hi = channel(src_rgb, c);
            blk = 255 - hi;
            exp.result_pixel = 32'hFF000000;
            for (c = 0; c < 3; c++) begin
               v = channel(color, c);
               v = (v < blk) ? 0 : v - blk;
               exp.result_pixel = exp.result_pixel | (32'(v) << (16 - 8 * c));
            end
         end
         exp.last_of_image = (col_pos == w - 1) && (row_pos == h - 1);
         col_pos++;
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
         end
         owed_pixels.push_back(exp);
      endfunction

      function void check_pixel(rsp_type got);
         rsp_type exp;
         if (owed_pixels.size() == 0) begin
            $error("unexpected result pixel %08h", got.result_pixel);
            failures++;
            return;
         end
         exp = owed_pixels.pop_front();
         if (got.result_pixel !== exp.result_pixel) begin
            $error("result_pixel: expected %08h, got %08h", exp.result_pixel, got.result_pixel);
            failures++;
         end
         if (got.last_of_image !== exp.last_of_image) begin
            $error("last_of_image: expected %0b, got %0b", exp.last_of_image,
                   got.last_of_image);
            failures++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DAT_W-1:0]  csr_data = '0;

   logic [31:0]           cycle_count = '0;
   int                    burst_left = 1;
   int                    stall_left = 0;
   recolor_scoreboard     sb;

   pixel_recolor_gradient i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL pixel_recolor_gradient");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_pixel(rsp_data);
   end

   // receiver backpressure: rotates through always-ready, random, periodic and long stalls
   always @(negedge clock) begin
      case (cycle_count[11:10])
         2'd0: rsp_ready <= 1'b1;
         2'd1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2'd2: rsp_ready <= ((cycle_count % 5) >= 2);
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_ready <= 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
               stall_left = $urandom_range(1, 24);
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      endcase
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_pixel(input logic [31:0] pixel, input logic first);
      req_type px;
      px.source_pixel = pixel;
      px.first_of_image = first;
      req_data <= px;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_pixel(px);
      @(negedge clock);
   endtask

   // csr_valid is left high; the caller lowers it after the last write
   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [CSR_DAT_W-1:0] data);
      csr_index <= index;
      csr_data <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(index, data);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // stop sending, let the pipeline empty, then leave room for register writes
   task automatic quiesce();
      req_valid <= 1'b0;
      wait_drained();
      repeat (4) @(negedge clock);
   endtask

   task automatic pace_sender();
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         if ($urandom_range(0, 39) == 0) wait_drained();
         else repeat ($urandom_range(1, 9)) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 250)
                                                  : $urandom_range(1, 12);
      end
   endtask

   function automatic logic [23:0] pick_color();
      case ($urandom_range(0, 3))
         0: return 24'h000000;
         1: return 24'hFFFFFF;
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [12:0] pick_dim();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 13'($urandom_range(1, 6));
      if (r < 78) return 13'd0;
      if (r < 90) return 13'($urandom_range(7, 64));
      if (r < 95) return 13'(MAX_DIM);
      return 13'($urandom_range(MAX_DIM + 1, 8191));
   endfunction

   function automatic logic [31:0] pick_pixel();
      logic [7:0] alpha;
      alpha = 8'($urandom);
      case ($urandom_range(0, 9))
         0, 1: return {alpha, sb.keep_rgb};
         2, 3: return {alpha, sb.key_rgb};
         4:    return {alpha, ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000000};
         default: return $urandom;
      endcase
   endfunction

   task automatic configure_phase(input bit write_all);
      logic [CSR_DAT_W-1:0] upper;
      upper = 24'($urandom);
      if (write_all || $urandom_range(0, 2) != 0)
         write_csr(CSR_MODE, {upper[23:1], 1'($urandom_range(0, 1))});
      if (write_all || $urandom_range(0, 2) != 0) write_csr(CSR_BASE_COLOR, pick_color());
      if (write_all || $urandom_range(0, 2) != 0) write_csr(CSR_END_COLOR, pick_color());
      if (write_all || $urandom_range(0, 2) != 0) write_csr(CSR_KEY_COLOR, pick_color());
      if (write_all || $urandom_range(0, 2) != 0) write_csr(CSR_KEEP_COLOR, pick_color());
      if (write_all || $urandom_range(0, 2) != 0) write_csr(CSR_WIDTH, {upper[23:13], pick_dim()});
      if (write_all || $urandom_range(0, 2) != 0)
         write_csr(CSR_HEIGHT, {upper[23:13], pick_dim()});
      if ($urandom_range(0, 15) == 0) write_csr(CSR_UNUSED, 24'($urandom));
      csr_valid <= 1'b0;
   endtask

   initial begin
      int   sent;
      int   count;
      int   img_size;
      int   pos;
      int   k;
      logic first;
      sb = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // no start mark after reset: color and steps still zero, 1x1 image
      send_pixel(32'h12000000, 1'b0);
      send_pixel(32'hABFFFFFF, 1'b0);
      send_pixel(32'h7F808080, 1'b0);
      send_pixel(32'hFF123456, 1'b0);

      quiesce();
      write_csr(CSR_MODE, 24'h000001);
      write_csr(CSR_BASE_COLOR, 24'h10F080);
      write_csr(CSR_END_COLOR, 24'hF01000);
      write_csr(CSR_KEY_COLOR, 24'h00FF00);
      write_csr(CSR_KEEP_COLOR, 24'h123456);
      write_csr(CSR_WIDTH, 24'h000003);
      write_csr(CSR_HEIGHT, 24'h000002);
      write_csr(CSR_UNUSED, 24'hFFFFFF);
      csr_valid <= 1'b0;
      // 3x2 gradient image, then pixels past the end so the channels saturate
      send_pixel(32'hFFFFFFFF, 1'b1);
      send_pixel(32'h00000000, 1'b0);
      send_pixel(32'h5500FF00, 1'b0);
      send_pixel(32'h80123456, 1'b0);
      send_pixel(32'h01020304, 1'b0);
      send_pixel(32'hFE7F7F7F, 1'b0);
      for (k = 0; k < 7; k++) send_pixel(32'hFF000000 | 32'(k * 24'h111111), 1'b0);

      // solid mode with zero width and an oversize height
      quiesce();
      write_csr(CSR_MODE, 24'h000000);
      write_csr(CSR_WIDTH, 24'h000000);
      write_csr(CSR_HEIGHT, 24'h001FFF);
      csr_valid <= 1'b0;
      send_pixel(32'h00FFFFFF, 1'b1);
      send_pixel(32'h3C000000 | 32'($urandom_range(0, 24'hFFFFFF)), 1'b0);
      send_pixel(32'hFF00FF00, 1'b0);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         quiesce();
         configure_phase(sent == 0);
         img_size = sb.fold_dim(sb.row_len) * sb.fold_dim(sb.row_total);
         if (img_size > 300) img_size = 300;
         count = (img_size <= 40) ? img_size * $urandom_range(1, 6) : $urandom_range(20, 150);
         pos = 0;
         for (k = 0; k < count; k++) begin
            first = (pos == 0);
            // occasional broken framing: a dropped or stray start mark
            if ($urandom_range(0, 24) == 0) first = ~first;
            send_pixel(pick_pixel(), first);
            pace_sender();
            pos = (pos + 1 == img_size) ? 0 : pos + 1;
            sent++;
         end
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (sb.failures == 0) begin
         $display("PASS pixel_recolor_gradient");
      end else begin
         $display("FAIL pixel_recolor_gradient");
      end
      $finish;
   end

endmodule
